FILE: hdl/multibit_trie_prefix_table_unit_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the multibit trie prefix table unit
// Clocked on clk_i, disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef MULTIBIT_TRIE_PREFIX_TABLE_UNIT_DEFINES_SVH
`define MULTIBIT_TRIE_PREFIX_TABLE_UNIT_DEFINES_SVH

// Same-cycle implication.
`define MTPT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define MTPT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/mtpt_pkg.sv
// ----------------------------------------------------------------------------
// mtpt_pkg
// Types, field widths and codes of the multibit trie prefix table unit.
// ----------------------------------------------------------------------------
`default_nettype none

package mtpt_pkg;

  localparam int KEY_BYTES_DEF  = 4;
  localparam int NODE_COUNT_DEF = 256;
  localparam int ROUTE_BITS_DEF = 16;

  localparam int STRIDE_BITS = 8;
  localparam int FANOUT      = 1 << STRIDE_BITS;

  localparam int REQ_W    = 2;
  localparam int KEY_W    = 32;
  localparam int LEN_W    = 6;
  localparam int DATA_W   = 16;
  localparam int ROUTE_W  = 16;
  localparam int STATUS_W = 3;
  localparam int CFG_W    = 2;

  localparam logic [CFG_W-1:0] MAX_LEVEL_RST = 2'd3;

  typedef enum logic [REQ_W-1:0] {
    REQ_LOOKUP = 2'd0,
    REQ_INSERT = 2'd1,
    REQ_DELETE = 2'd2
  } req_type_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK        = 3'd0,
    STAT_REPLACED  = 3'd1,
    STAT_NOT_FOUND = 3'd2,
    STAT_FULL      = 3'd3,
    STAT_BAD_LEN   = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    SM_CLEAR,
    SM_IDLE,
    SM_WALK,
    SM_ALLOC,
    SM_RESP
  } mtpt_state_e;

endpackage

`default_nettype wire

FILE: hdl/mtpt_if.sv
// ----------------------------------------------------------------------------
// mtpt channel interfaces
// Request, response and configuration channels with valid/ready transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface mtpt_req_if;
  import mtpt_pkg::*;
  logic               valid;
  logic               ready;
  logic [REQ_W-1:0]   req_type;
  logic [KEY_W-1:0]   key;
  logic [LEN_W-1:0]   prefix_len;
  logic [DATA_W-1:0]  route_data;

  modport source (output valid, req_type, key, prefix_len, route_data, input ready);
  modport sink   (input valid, req_type, key, prefix_len, route_data, output ready);
endinterface

interface mtpt_rsp_if;
  import mtpt_pkg::*;
  logic                valid;
  logic                ready;
  logic                found;
  logic [ROUTE_W-1:0]  route;
  logic [STATUS_W-1:0] status;

  modport source (output valid, found, route, status, input ready);
  modport sink   (input valid, found, route, status, output ready);
endinterface

interface mtpt_cfg_if;
  import mtpt_pkg::*;
  logic             valid;
  logic             ready;
  logic [CFG_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

FILE: hdl/multibit_trie_prefix_table_unit.sv
// ----------------------------------------------------------------------------
// multibit_trie_prefix_table_unit
// Longest-prefix route table: 8-bit stride trie in one node memory.
// ----------------------------------------------------------------------------
//  channel | dir | fields
//  req_i   | in  | req_type, key, prefix_len, route_data
//  rsp_o   | out | found, route, status
//  cfg_i   | in  | data (max_level)
//
//  One memory read per trie level reached; a write to an entry that was read
//  happens in the cycle its read data is used, while nodes allocated in
//  SM_ALLOC are written without a read.
//  After reset a clearing pass writes NODE_COUNT*256 entries, one per cycle;
//  req_i is held off until it ends, cfg_i is taken throughout.
//  A new request is taken while the previous response waits on rsp_o; its
//  own response holds in SM_RESP until rsp_o is free.
// ----------------------------------------------------------------------------
`default_nettype none

`include "multibit_trie_prefix_table_unit_defines.svh"

module multibit_trie_prefix_table_unit #(
  parameter int KEY_BYTES  = mtpt_pkg::KEY_BYTES_DEF,
  parameter int NODE_COUNT = mtpt_pkg::NODE_COUNT_DEF,
  parameter int ROUTE_BITS = mtpt_pkg::ROUTE_BITS_DEF
) (
  input  wire       clk_i,
  input  wire       rst_ni,
  mtpt_req_if.sink   req_i,
  mtpt_rsp_if.source rsp_o,
  mtpt_cfg_if.sink   cfg_i
);

  import mtpt_pkg::*;

  localparam int NW       = $clog2(NODE_COUNT);
  localparam int FW       = $clog2(NODE_COUNT + 1);
  localparam int FW1      = FW + 1;
  localparam int AW       = NW + STRIDE_BITS;
  localparam int DEPTH    = NODE_COUNT * FANOUT;
  localparam int EW       = NW + 2 + ROUTE_BITS;
  localparam int KEYX_W   = (KEY_BYTES * 8 > KEY_W) ? KEY_BYTES * 8 : KEY_W;
  localparam int LAST_BYTE = KEY_BYTES - 1;

  function automatic logic [STRIDE_BITS-1:0] key_byte(input logic [KEY_W-1:0] k,
                                                       input logic [1:0] lvl);
    logic [KEYX_W-1:0] ext;
    int                sh;
    ext = KEYX_W'(k);
    sh  = 8 * (LAST_BYTE - int'(lvl));
    if (sh < 0) begin
      return '0;
    end
    return STRIDE_BITS'(ext >> sh);
  endfunction

  mtpt_state_e state_q, state_d;

  logic [AW-1:0]         clr_q, clr_d;
  logic [FW-1:0]         nfree_q, nfree_d;
  logic [CFG_W-1:0]      max_level_q;
  logic [1:0]            lvl_q, lvl_d;
  logic                  hit_q, hit_d;
  logic [ROUTE_BITS-1:0] hitr_q, hitr_d;
  logic [AW-1:0]         addr_q;

  logic [REQ_W-1:0]      req_q;
  logic [KEY_W-1:0]      key_q;
  logic [1:0]            tgt_q;
  logic [ROUTE_BITS-1:0] data_q;

  logic                  res_found_q, res_found_d;
  logic [ROUTE_W-1:0]    res_route_q, res_route_d;
  logic [STATUS_W-1:0]   res_status_q, res_status_d;

  logic                  out_valid_q, out_valid_d;
  logic                  out_found_q;
  logic [ROUTE_W-1:0]    out_route_q;
  logic [STATUS_W-1:0]   out_status_q;
  logic                  out_load;

  logic [EW-1:0]         mem_q [DEPTH];
  logic [EW-1:0]         rdata_q;
  logic                  re, we;
  logic [AW-1:0]         raddr, waddr;
  logic [EW-1:0]         wdata;

  logic                  ent_cv, ent_rv;
  logic [NW-1:0]         ent_child;
  logic [ROUTE_BITS-1:0] ent_route;

  logic                  accept, len_bad, walk_req, at_tgt, lk_more, full, clr_done, out_free;
  logic [1:0]            last_lvl, tgt_in;
  logic [2:0]            missing;
  logic [FW1-1:0]        room;
  logic [NW-1:0]         new_node;

  assign ent_route = rdata_q[ROUTE_BITS-1:0];
  assign ent_rv    = rdata_q[ROUTE_BITS];
  assign ent_cv    = rdata_q[ROUTE_BITS+1];
  assign ent_child = rdata_q[EW-1:ROUTE_BITS+2];

  assign last_lvl = (int'(max_level_q) < LAST_BYTE) ? max_level_q : 2'(LAST_BYTE);
  assign len_bad  = (req_i.prefix_len == '0) || (req_i.prefix_len[2:0] != 3'd0) ||
                    (req_i.prefix_len > 6'({3'(last_lvl) + 3'd1, 3'b000}));
  assign tgt_in   = 2'(req_i.prefix_len[LEN_W-1:3] - 3'd1);
  assign walk_req = (req_i.req_type == REQ_LOOKUP) ||
                    (((req_i.req_type == REQ_INSERT) || (req_i.req_type == REQ_DELETE))
                     && !len_bad);

  assign req_i.ready = (state_q == SM_IDLE);
  assign accept      = req_i.valid && req_i.ready;
  assign cfg_i.ready = 1'b1;

  assign at_tgt   = (lvl_q == tgt_q);
  assign lk_more  = ent_cv && (lvl_q < last_lvl);
  assign missing  = 3'(tgt_q) - 3'(lvl_q);
  assign room     = FW1'(NODE_COUNT) - FW1'(nfree_q);
  assign full     = FW1'(missing) > room;
  assign clr_done = (clr_q == AW'(DEPTH - 1));
  assign out_free = !out_valid_q || rsp_o.ready;
  assign new_node = NW'(nfree_q - FW'(1));

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      SM_CLEAR: begin
        if (clr_done) state_d = SM_IDLE;
      end
      SM_IDLE: begin
        if (accept) state_d = walk_req ? SM_WALK : SM_RESP;
      end
      SM_WALK: begin
        unique case (req_q)
          REQ_LOOKUP: state_d = lk_more ? SM_WALK : SM_RESP;
          REQ_INSERT: begin
            if (at_tgt)      state_d = SM_RESP;
            else if (ent_cv) state_d = SM_WALK;
            else             state_d = full ? SM_RESP : SM_ALLOC;
          end
          REQ_DELETE: state_d = (!at_tgt && ent_cv) ? SM_WALK : SM_RESP;
          default:    state_d = SM_RESP;
        endcase
      end
      SM_ALLOC: begin
        if (at_tgt) state_d = SM_RESP;
      end
      SM_RESP: begin
        if (out_free) state_d = SM_IDLE;
      end
      default: state_d = SM_IDLE;
    endcase
  end

  always_comb begin
    clr_d        = clr_q;
    nfree_d      = nfree_q;
    lvl_d        = lvl_q;
    hit_d        = hit_q;
    hitr_d       = hitr_q;
    res_found_d  = res_found_q;
    res_route_d  = res_route_q;
    res_status_d = res_status_q;
    re           = 1'b0;
    raddr        = '0;
    we           = 1'b0;
    waddr        = addr_q;
    wdata        = '0;
    out_load     = 1'b0;
    unique case (state_q)
      SM_CLEAR: begin
        we    = 1'b1;
        waddr = clr_q;
        clr_d = clr_q + AW'(1);
      end
      SM_IDLE: begin
        if (accept) begin
          lvl_d        = 2'd0;
          hit_d        = 1'b0;
          res_found_d  = 1'b0;
          res_route_d  = '0;
          res_status_d = (req_i.req_type == REQ_LOOKUP || req_i.req_type == REQ_INSERT ||
                          req_i.req_type == REQ_DELETE) ? STAT_BAD_LEN : STAT_OK;
          if (walk_req) begin
            re    = 1'b1;
            raddr = {NW'(0), key_byte(req_i.key, 2'd0)};
          end
        end
      end
      SM_WALK: begin
        unique case (req_q)
          REQ_LOOKUP: begin
            if (ent_rv) begin
              hit_d  = 1'b1;
              hitr_d = ent_route;
            end
            if (lk_more) begin
              re    = 1'b1;
              raddr = {ent_child, key_byte(key_q, lvl_q + 2'd1)};
              lvl_d = lvl_q + 2'd1;
            end else begin
              res_found_d  = hit_q || ent_rv;
              res_route_d  = ent_rv ? ROUTE_W'(ent_route) :
                             (hit_q ? ROUTE_W'(hitr_q) : '0);
              res_status_d = (hit_q || ent_rv) ? STAT_OK : STAT_NOT_FOUND;
            end
          end
          REQ_INSERT: begin
            if (!at_tgt) begin
              if (ent_cv) begin
                re    = 1'b1;
                raddr = {ent_child, key_byte(key_q, lvl_q + 2'd1)};
                lvl_d = lvl_q + 2'd1;
              end else if (full) begin
                res_status_d = STAT_FULL;
              end else begin
                we      = 1'b1;
                wdata   = {NW'(nfree_q), 1'b1, ent_rv, ent_route};
                nfree_d = nfree_q + FW'(1);
                lvl_d   = lvl_q + 2'd1;
              end
            end else begin
              we           = 1'b1;
              wdata        = {ent_child, ent_cv, 1'b1, data_q};
              res_status_d = ent_rv ? STAT_REPLACED : STAT_OK;
            end
          end
          REQ_DELETE: begin
            if (!at_tgt) begin
              if (ent_cv) begin
                re    = 1'b1;
                raddr = {ent_child, key_byte(key_q, lvl_q + 2'd1)};
                lvl_d = lvl_q + 2'd1;
              end else begin
                res_status_d = STAT_NOT_FOUND;
              end
            end else if (ent_rv) begin
              we           = 1'b1;
              wdata        = {ent_child, ent_cv, 1'b0, ROUTE_BITS'(0)};
              res_status_d = STAT_OK;
            end else begin
              res_status_d = STAT_NOT_FOUND;
            end
          end
          default: begin
            res_status_d = STAT_OK;
          end
        endcase
      end
      SM_ALLOC: begin
        we    = 1'b1;
        waddr = {new_node, key_byte(key_q, lvl_q)};
        if (!at_tgt) begin
          wdata   = {NW'(nfree_q), 1'b1, 1'b0, ROUTE_BITS'(0)};
          nfree_d = nfree_q + FW'(1);
          lvl_d   = lvl_q + 2'd1;
        end else begin
          wdata        = {NW'(0), 1'b0, 1'b1, data_q};
          res_status_d = STAT_OK;
        end
      end
      SM_RESP: begin
        out_load = out_free;
      end
      default: ;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SM_CLEAR;
      clr_q       <= '0;
      nfree_q     <= FW'(1);
      max_level_q <= MAX_LEVEL_RST;
      lvl_q       <= '0;
      hit_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      nfree_q     <= nfree_d;
      lvl_q       <= lvl_d;
      hit_q       <= hit_d;
      out_valid_q <= out_valid_d;
      if (cfg_i.valid && cfg_i.ready) begin
        max_level_q <= cfg_i.data;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    hitr_q       <= hitr_d;
    res_found_q  <= res_found_d;
    res_route_q  <= res_route_d;
    res_status_q <= res_status_d;
    if (accept) begin
      req_q  <= req_i.req_type;
      key_q  <= req_i.key;
      tgt_q  <= tgt_in;
      data_q <= ROUTE_BITS'(req_i.route_data);
    end
    if (re) begin
      addr_q <= raddr;
    end
    if (out_load) begin
      out_found_q  <= res_found_q;
      out_route_q  <= res_route_q;
      out_status_q <= res_status_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    if (re) begin
      rdata_q <= mem_q[raddr];
    end
  end

  assign rsp_o.valid  = out_valid_q;
  assign rsp_o.found  = out_found_q;
  assign rsp_o.route  = out_route_q;
  assign rsp_o.status = out_status_q;

  `MTPT_ASSERT_NOW(a_nfree_range, 1'b1, (nfree_q != '0) && (nfree_q <= FW'(NODE_COUNT)), "bad node count")
  `MTPT_ASSERT_NOW(a_no_rw_clash, re && we, raddr != waddr, "same-entry read and write")
  `MTPT_ASSERT_NOW(a_alloc_depth, state_q == SM_ALLOC, lvl_q <= tgt_q, "allocation past target level")
  `MTPT_ASSERT_NEXT(a_accept_busy, accept, state_q != SM_IDLE, "request transfer left unit idle")

endmodule

`default_nettype wire
